### hdl/swae_pkg.sv
package swae_pkg;

  localparam int unsigned SeqW = 3;
  localparam int unsigned ChkMarks = 8;

  localparam logic [2:0] ACT_DATA    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_NAK     = 3'd2;
  localparam logic [2:0] ACT_CHECK   = 3'd3;
  localparam logic [2:0] ACT_END_SEQ = 3'd4;
  localparam logic [2:0] ACT_TIMEOUT = 3'd5;
  localparam logic [2:0] ACT_QUEUE   = 3'd6;
  localparam logic [2:0] ACT_NONE    = 3'd7;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_NAK     = 3'd1,
    KIND_RESEND  = 3'd2,
    KIND_CHECK   = 3'd3,
    KIND_DELIVER = 3'd4,
    KIND_TX_NEW  = 3'd5,
    KIND_FULL    = 3'd6
  } kind_e;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [SeqW-1:0] win;
  } swae_emit_t;

  typedef enum logic [3:0] {
    UOP_FLUSH,
    UOP_DISPATCH,
    UOP_DATA_MARK,
    UOP_DELIVER,
    UOP_ANSWER,
    UOP_ACK_CLEAR,
    UOP_RETIRE,
    UOP_NAK,
    UOP_TIMEOUT,
    UOP_QUEUE,
    UOP_END
  } uop_e;

  typedef logic [3:0] upc_t;

  localparam upc_t PC_FLUSH      = 4'd0;
  localparam upc_t PC_DISPATCH   = 4'd1;
  localparam upc_t PC_DATA_MARK  = 4'd2;
  localparam upc_t PC_DELIVER    = 4'd3;
  localparam upc_t PC_ANSWER     = 4'd4;
  localparam upc_t PC_ACK_CLEAR  = 4'd5;
  localparam upc_t PC_ACK_RETIRE = 4'd6;
  localparam upc_t PC_NAK        = 4'd7;
  localparam upc_t PC_TIMEOUT    = 4'd8;
  localparam upc_t PC_Q_RETIRE   = 4'd9;
  localparam upc_t PC_QUEUE      = 4'd10;
  localparam upc_t PC_END        = 4'd11;

  typedef struct packed {
    uop_e uop;
    upc_t next;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input upc_t pc);
    ctrl_word_t w;
    unique case (pc)
      PC_FLUSH:      w = '{uop: UOP_FLUSH,     next: PC_DISPATCH};
      PC_DISPATCH:   w = '{uop: UOP_DISPATCH,  next: PC_END};
      PC_DATA_MARK:  w = '{uop: UOP_DATA_MARK, next: PC_DELIVER};
      PC_DELIVER:    w = '{uop: UOP_DELIVER,   next: PC_ANSWER};
      PC_ANSWER:     w = '{uop: UOP_ANSWER,    next: PC_END};
      PC_ACK_CLEAR:  w = '{uop: UOP_ACK_CLEAR, next: PC_ACK_RETIRE};
      PC_ACK_RETIRE: w = '{uop: UOP_RETIRE,    next: PC_END};
      PC_NAK:        w = '{uop: UOP_NAK,       next: PC_END};
      PC_TIMEOUT:    w = '{uop: UOP_TIMEOUT,   next: PC_END};
      PC_Q_RETIRE:   w = '{uop: UOP_RETIRE,    next: PC_QUEUE};
      PC_QUEUE:      w = '{uop: UOP_QUEUE,     next: PC_END};
      default:       w = '{uop: UOP_END,       next: PC_END};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch_target(input logic [2:0] action);
    upc_t t;
    unique case (action)
      ACT_DATA:    t = PC_DATA_MARK;
      ACT_ACK:     t = PC_ACK_CLEAR;
      ACT_NAK:     t = PC_NAK;
      ACT_TIMEOUT: t = PC_TIMEOUT;
      ACT_QUEUE:   t = PC_Q_RETIRE;
      default:     t = PC_END;
    endcase
    return t;
  endfunction

endpackage

### hdl/swae_out_stage.sv
module swae_out_stage
  import swae_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  swae_emit_t emit_i,
  input  logic       finish_i,
  output logic       stall_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [2:0] out_window, [7:3] zero
  output logic [2:0] m_axis_tuser,  // [2:0] kind
  output logic       m_axis_tlast
);

  logic            pend_valid_q;
  kind_e           pend_kind_q;
  logic [SeqW-1:0] pend_win_q;
  logic            out_valid_q;
  kind_e           out_kind_q;
  logic [SeqW-1:0] out_win_q;
  logic            out_last_q;
  logic            out_busy;
  logic            need_push;

  // one result is held back so the final one of an item can be tagged last
  assign out_busy  = out_valid_q && !m_axis_tready;
  assign need_push = pend_valid_q && (emit_i.valid || finish_i);
  assign stall_o   = need_push && out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (!stall_o) begin
      if (need_push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (emit_i.valid) begin
        pend_valid_q <= 1'b1;
      end else if (finish_i) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      if (need_push) begin
        out_kind_q <= pend_kind_q;
        out_win_q  <= pend_win_q;
        out_last_q <= finish_i;
      end
      if (emit_i.valid) begin
        pend_kind_q <= emit_i.kind;
        pend_win_q  <= emit_i.win;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_win_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/sliding_window_ack_engine_core.sv
// Selective-repeat window controller, WINDOW_SLOTS receive and transmit windows in a
// modulo-8 sequence space. Each input item is one link event (action in tuser, sequence
// number in tdata); each result carries its kind in tuser, the sequence number in tdata
// and tlast on the final result of the item. Check and unknown events are absorbed in
// the accept cycle. Every other event runs a short microprogram, one control word per
// cycle while the output stage does not stall, and holds tready low from its accept
// through its closing step: a flush step that skips or scans the check marks (always
// scanned for end of sequence), one dispatch step, one step per delivered or retired
// window plus one that finds the head empty, one per window slot for a timeout, one
// mark, nak or queue step and the closing step. With four windows the longest item is
// data with pending checks that delivers four windows; the output side can also hold
// tready low once the held-back result and the output register are both full.
module sliding_window_ack_engine_core
  import swae_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [2:0] window, [7:3] zero
  input  logic [2:0] s_axis_tuser,  // [2:0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [2:0] out_window, [7:3] zero
  output logic [2:0] m_axis_tuser,  // [2:0] kind
  output logic       m_axis_tlast
);

  localparam logic [2:0] Slots3   = 3'(WINDOW_SLOTS);
  localparam logic [2:0] LastSlot = 3'(WINDOW_SLOTS - 1);
  localparam logic [2:0] LastMark = 3'(ChkMarks - 1);

  logic                    busy_q, busy_d;
  upc_t                    upc_q, upc_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [2:0]              act_q;
  logic [SeqW-1:0]         win_q;
  logic [WINDOW_SLOTS-1:0] rx_ready_q, rx_ready_d;
  logic [SeqW-1:0]         rx_start_q, rx_start_d;
  logic [WINDOW_SLOTS-1:0] tx_pend_q, tx_pend_d;
  logic [SeqW-1:0]         tx_start_q, tx_start_d;
  logic [2:0]              tx_used_q, tx_used_d;
  logic [ChkMarks-1:0]     marks_q, marks_d;
  logic                    chk_act_q, chk_act_d;

  ctrl_word_t      cw;
  swae_emit_t      emit;
  logic            finish;
  logic            stall;
  logic            accept;
  logic [2:0]      in_act;
  logic [SeqW-1:0] in_win;
  logic [SeqW-1:0] rx_off;
  logic [SeqW-1:0] tx_off;
  logic            tx_in;

  function automatic logic pick(input logic [WINDOW_SLOTS-1:0] v, input logic [2:0] idx);
    logic r;
    r = 1'b0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (idx == 3'(i)) r = v[i];
    end
    return r;
  endfunction

  function automatic logic [WINDOW_SLOTS-1:0] put(input logic [WINDOW_SLOTS-1:0] v,
                                                   input logic [2:0] idx, input logic b);
    logic [WINDOW_SLOTS-1:0] r;
    r = v;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (idx == 3'(i)) r[i] = b;
    end
    return r;
  endfunction

  function automatic kind_e answer_kind(input logic [SeqW-1:0] w, input logic [SeqW-1:0] st,
                                        input logic [WINDOW_SLOTS-1:0] rdy);
    logic [SeqW-1:0] off;
    off = w - st;
    return (off < Slots3 && !pick(rdy, off)) ? KIND_NAK : KIND_ACK;
  endfunction

  assign in_act        = s_axis_tuser;
  assign in_win        = s_axis_tdata[2:0];
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cw            = ucode_rom(upc_q);
  assign rx_off        = win_q - rx_start_q;
  assign tx_off        = win_q - tx_start_q;
  assign tx_in         = (tx_off < tx_used_q) && (tx_off < Slots3);

  always_comb begin
    busy_d     = busy_q;
    upc_d      = upc_q;
    cnt_d      = cnt_q;
    rx_ready_d = rx_ready_q;
    rx_start_d = rx_start_q;
    tx_pend_d  = tx_pend_q;
    tx_start_d = tx_start_q;
    tx_used_d  = tx_used_q;
    marks_d    = marks_q;
    chk_act_d  = chk_act_q;
    emit       = '{valid: 1'b0, kind: KIND_ACK, win: '0};
    finish     = 1'b0;

    if (!busy_q) begin
      if (accept) begin
        if (in_act == ACT_CHECK) begin
          marks_d[in_win] = 1'b1;
          chk_act_d       = 1'b1;
        end else if (in_act != ACT_NONE) begin
          busy_d = 1'b1;
          upc_d  = PC_FLUSH;
          cnt_d  = '0;
        end
      end
    end else begin
      unique case (cw.uop)
        UOP_FLUSH: begin
          if (act_q == ACT_END_SEQ || chk_act_q) begin
            emit = '{valid: marks_q[cnt_q],
                     kind: answer_kind(cnt_q, rx_start_q, rx_ready_q), win: cnt_q};
            if (!stall) begin
              marks_d[cnt_q] = 1'b0;
              if (cnt_q == LastMark) begin
                chk_act_d = 1'b0;
                cnt_d     = '0;
                upc_d     = cw.next;
              end else begin
                cnt_d = cnt_q + 3'd1;
              end
            end
          end else begin
            upc_d = cw.next;
          end
        end
        UOP_DISPATCH: begin
          upc_d = dispatch_target(act_q);
        end
        UOP_DATA_MARK: begin
          if (rx_off < Slots3) begin
            rx_ready_d = put(rx_ready_q, rx_off, 1'b1);
            upc_d      = cw.next;
          end else begin
            upc_d = PC_ANSWER;
          end
        end
        UOP_DELIVER: begin
          if (rx_ready_q[0]) begin
            emit = '{valid: 1'b1, kind: KIND_DELIVER, win: rx_start_q};
            if (!stall) begin
              rx_ready_d = rx_ready_q >> 1;
              rx_start_d = rx_start_q + 3'd1;
            end
          end else begin
            upc_d = cw.next;
          end
        end
        UOP_ANSWER: begin
          emit = '{valid: 1'b1, kind: answer_kind(win_q, rx_start_q, rx_ready_q), win: win_q};
          if (!stall) upc_d = cw.next;
        end
        UOP_ACK_CLEAR: begin
          if (tx_in) tx_pend_d = put(tx_pend_q, tx_off, 1'b0);
          upc_d = cw.next;
        end
        UOP_RETIRE: begin
          if (tx_used_q != 3'd0 && !tx_pend_q[0]) begin
            tx_pend_d  = tx_pend_q >> 1;
            tx_used_d  = tx_used_q - 3'd1;
            tx_start_d = tx_start_q + 3'd1;
          end else begin
            upc_d = cw.next;
          end
        end
        UOP_NAK: begin
          emit = '{valid: tx_in, kind: KIND_RESEND, win: win_q};
          if (!stall) upc_d = cw.next;
        end
        UOP_TIMEOUT: begin
          emit = '{valid: (cnt_q < tx_used_q) && pick(tx_pend_q, cnt_q),
                   kind: KIND_CHECK, win: tx_start_q + cnt_q};
          if (!stall) begin
            if (cnt_q == LastSlot) begin
              cnt_d = '0;
              upc_d = cw.next;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end
        end
        UOP_QUEUE: begin
          if (tx_used_q < Slots3) begin
            emit = '{valid: 1'b1, kind: KIND_TX_NEW, win: tx_start_q + tx_used_q};
            if (!stall) begin
              tx_pend_d = put(tx_pend_q, tx_used_q, 1'b1);
              tx_used_d = tx_used_q + 3'd1;
            end
          end else begin
            emit = '{valid: 1'b1, kind: KIND_FULL, win: tx_start_q};
          end
          if (!stall) upc_d = cw.next;
        end
        UOP_END: begin
          finish = 1'b1;
          if (!stall) busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      upc_q      <= PC_FLUSH;
      cnt_q      <= '0;
      rx_ready_q <= '0;
      rx_start_q <= '0;
      tx_pend_q  <= '0;
      tx_start_q <= '0;
      tx_used_q  <= '0;
      marks_q    <= '0;
      chk_act_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      upc_q      <= upc_d;
      cnt_q      <= cnt_d;
      rx_ready_q <= rx_ready_d;
      rx_start_q <= rx_start_d;
      tx_pend_q  <= tx_pend_d;
      tx_start_q <= tx_start_d;
      tx_used_q  <= tx_used_d;
      marks_q    <= marks_d;
      chk_act_q  <= chk_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_act;
      win_q <= in_win;
    end
  end

  swae_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .finish_i      (finish),
    .stall_o       (stall),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/sv/tb_sliding_window_ack_engine_core.sv
`timescale 1ns / 100ps

module tb_sliding_window_ack_engine_core;
  import swae_pkg::*;

  localparam int unsigned WSLOTS = 4;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    kind_e      kind;
    logic [2:0] win;
    logic       last;
  } link_reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [2:0] window, [7:3] zero
  logic [2:0] s_axis_tuser = 3'd0;   // [2:0] action
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [2:0] out_window, [7:3] zero
  logic [2:0] m_axis_tuser;          // [2:0] kind
  logic       m_axis_tlast;

  sliding_window_ack_engine_core #(
    .WINDOW_SLOTS(WSLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // link state mirror
  logic       rx_rdy [WSLOTS] = '{default: 1'b0};
  logic [2:0] rx_base = 3'd0;
  logic       tx_pend [WSLOTS] = '{default: 1'b0};
  logic [2:0] tx_base = 3'd0;
  logic [2:0] tx_cnt = 3'd0;
  logic       chk_mark [8] = '{default: 1'b0};
  logic       chk_any = 1'b0;

  link_reply_t step_replies[$];
  link_reply_t pending_replies[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      sink_hold <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void add_reply(input kind_e k, input logic [2:0] w);
    step_replies.push_back('{kind: k, win: w, last: 1'b0});
  endfunction

  function automatic void answer_window(input logic [2:0] w);
    logic [2:0] off;
    off = w - rx_base;
    if (off >= WSLOTS || rx_rdy[off]) add_reply(KIND_ACK, w);
    else add_reply(KIND_NAK, w);
  endfunction

  function automatic void answer_checks();
    for (int i = 0; i < 8; i++) begin
      if (chk_mark[i]) answer_window(3'(i));
      chk_mark[i] = 1'b0;
    end
    chk_any = 1'b0;
  endfunction

  function automatic void retire_acked();
    while (tx_cnt > 0 && !tx_pend[0]) begin
      for (int i = 0; i + 1 < WSLOTS; i++) tx_pend[i] = tx_pend[i+1];
      tx_pend[WSLOTS-1] = 1'b0;
      tx_cnt = tx_cnt - 3'd1;
      tx_base = tx_base + 3'd1;
    end
  endfunction

  function automatic void advance_link_state(input logic [2:0] act, input logic [2:0] w);
    logic [2:0] off;
    step_replies.delete();
    if (act == ACT_NONE) return;
    if (act == ACT_CHECK) begin
      chk_mark[w] = 1'b1;
      chk_any = 1'b1;
      return;
    end
    if (act == ACT_END_SEQ || chk_any) answer_checks();
    case (act)
      ACT_DATA: begin
        off = w - rx_base;
        if (off < WSLOTS) begin
          rx_rdy[off] = 1'b1;
          while (rx_rdy[0]) begin
            add_reply(KIND_DELIVER, rx_base);
            for (int i = 0; i + 1 < WSLOTS; i++) rx_rdy[i] = rx_rdy[i+1];
            rx_rdy[WSLOTS-1] = 1'b0;
            rx_base = rx_base + 3'd1;
          end
        end
        answer_window(w);
      end
      ACT_ACK: begin
        off = w - tx_base;
        if (off < tx_cnt) tx_pend[off] = 1'b0;
        retire_acked();
      end
      ACT_NAK: begin
        off = w - tx_base;
        if (off < tx_cnt) add_reply(KIND_RESEND, w);
      end
      ACT_TIMEOUT: begin
        for (int i = 0; i < tx_cnt; i++)
          if (tx_pend[i]) add_reply(KIND_CHECK, 3'(tx_base + i));
      end
      ACT_QUEUE: begin
        retire_acked();
        if (tx_cnt < WSLOTS) begin
          tx_pend[tx_cnt] = 1'b1;
          add_reply(KIND_TX_NEW, 3'(tx_base + tx_cnt));
          tx_cnt = tx_cnt + 3'd1;
        end else begin
          add_reply(KIND_FULL, tx_base);
        end
      end
      default: ;
    endcase
    if (step_replies.size() > 0) step_replies[step_replies.size()-1].last = 1'b1;
    foreach (step_replies[i]) pending_replies.push_back(step_replies[i]);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    link_reply_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        advance_link_state(s_axis_tuser, s_axis_tdata[2:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          flag_error($sformatf("unexpected item kind=%0d tdata=%0h last=%0b",
                               m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          want = pending_replies.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata !== {5'd0, want.win} ||
              m_axis_tlast !== want.last)
            flag_error($sformatf("expected kind=%0d win=%0d last=%0b, got kind=%0d tdata=%0h last=%0b",
                                 want.kind, want.win, want.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  task automatic send_event(input logic [2:0] act, input logic [2:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {5'd0, w};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic test_directed_events();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // fill transmit windows, then one more for window full
    repeat (5) send_event(ACT_QUEUE, 3'd0);
    send_event(ACT_NAK, 3'd2);
    // nak outside the used windows
    send_event(ACT_NAK, 3'd6);
    send_event(ACT_TIMEOUT, 3'd7);
    send_event(ACT_ACK, 3'd1);
    send_event(ACT_ACK, 3'd0);
    // stray ack
    send_event(ACT_ACK, 3'd5);
    // out of order data, then in-order delivery chains
    send_event(ACT_DATA, 3'd1);
    send_event(ACT_DATA, 3'd3);
    send_event(ACT_DATA, 3'd0);
    send_event(ACT_DATA, 3'd2);
    // data outside the receive window
    send_event(ACT_DATA, 3'd0);
    send_event(ACT_CHECK, 3'd5);
    send_event(ACT_CHECK, 3'd0);
    send_event(ACT_CHECK, 3'd7);
    send_event(ACT_NONE, 3'd7);
    send_event(ACT_END_SEQ, 3'd0);
    // end of sequence with nothing marked
    send_event(ACT_END_SEQ, 3'd3);
    send_event(ACT_CHECK, 3'd6);
    send_event(ACT_QUEUE, 3'd0);
    send_event(ACT_TIMEOUT, 3'd0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned src_pct,
                                     input int unsigned snk_pct);
    int unsigned r;
    logic [2:0] act;
    logic [2:0] w;
    src_idle_pct = src_pct;
    sink_stall_pct = snk_pct;
    for (int unsigned k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 25) act = ACT_DATA;
      else if (r < 40) act = ACT_ACK;
      else if (r < 50) act = ACT_NAK;
      else if (r < 62) act = ACT_CHECK;
      else if (r < 67) act = ACT_END_SEQ;
      else if (r < 74) act = ACT_TIMEOUT;
      else if (r < 97) act = ACT_QUEUE;
      else act = ACT_NONE;
      if ($urandom_range(3) == 0) w = 3'($urandom);
      else if (act == ACT_DATA || act == ACT_CHECK) w = rx_base + 3'($urandom_range(3));
      else w = tx_base + 3'($urandom_range(3));
      send_event(act, w);
    end
  endtask

  task automatic test_output_holdoff();
    logic [2:0] w;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req++;
    for (int k = 0; k < 30; k++) begin
      w = 3'($urandom);
      case ($urandom_range(3))
        0: send_event(ACT_QUEUE, w);
        1: send_event(ACT_TIMEOUT, w);
        2: send_event(ACT_CHECK, w);
        default: send_event(ACT_DATA, w);
      endcase
    end
  endtask

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed_events();
    test_random_traffic(26, 0, 0);
    test_random_traffic(26, 76, 0);
    test_random_traffic(26, 0, 76);
    test_random_traffic(26, 36, 36);
    test_output_holdoff();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      err_count++;
      $display("%0d expected items never arrived", pending_replies.size());
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/swae_pkg.sv
hdl/swae_out_stage.sv
hdl/sliding_window_ack_engine_core.sv
tb/sv/tb_sliding_window_ack_engine_core.sv
